// ===== hw/rtl/des_pkg.sv =====
// DES package: FIPS 46 permutation tables, S-boxes and helper functions.
// Used by des_key_sched, des_feistel_stage and des_block_cipher.
package des_pkg;

    localparam int unsigned ROUNDS = 16;
    localparam int unsigned BLK_W  = 64;
    localparam int unsigned KEY_W  = 64;
    localparam int unsigned SUB_W  = 48;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DES_KEY      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENCRYPT_MODE = 1'd1;

    typedef logic [SUB_W-1:0] t_subkey;
    typedef t_subkey t_subkeys [ROUNDS];

    typedef struct packed {
        logic        valid;
        logic        parity_ok;
        logic [31:0] l;
        logic [31:0] r;
    } t_stage;

    typedef byte unsigned t_tab64 [64];
    typedef byte unsigned t_tab56 [56];
    typedef byte unsigned t_tab48 [48];
    typedef byte unsigned t_tab32 [32];

    localparam t_tab64 TAB_IP = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };

    localparam t_tab64 TAB_FP = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

    localparam t_tab48 TAB_E = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1 };

    localparam t_tab32 TAB_P = '{
        16,7,20,21, 29,12,28,17, 1,15,23,26, 5,18,31,10,
        2,8,24,14, 32,27,3,9, 19,13,30,6, 22,11,4,25 };

    localparam t_tab56 TAB_PC1 = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4 };

    localparam t_tab48 TAB_PC2 = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8,
        16,7,27,20,13,2, 41,52,31,37,47,55, 30,40,51,45,33,48,
        44,49,39,56,34,53, 46,42,50,36,29,32 };

    localparam logic [ROUNDS-1:0] ROT_TWO = 16'b0111_1110_1111_1100;

    typedef logic [3:0] t_sbox [8][64];
    localparam t_sbox TAB_S = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
          0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
          15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
          3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
          13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
          13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
          1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
          13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
          3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
          14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
          11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
          10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
          4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
          13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
          6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
          1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
          2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11} };

    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_IP[i]];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_FP[i]];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-TAB_PC1[i]];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-TAB_PC2[i]];
        return r;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input t_subkey k);
        logic [47:0] x;
        logic [31:0] o;
        logic [5:0]  g;
        logic [31:0] p;
        for (int i = 0; i < 48; i++) x[47-i] = r[32-TAB_E[i]];
        x = x ^ k;
        for (int i = 0; i < 8; i++) begin
            g = x[47-6*i -: 6];
            o[31-4*i -: 4] = TAB_S[i][{g[5], g[0], g[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = o[32-TAB_P[i]];
        return p;
    endfunction

    function automatic logic key_parity(input logic [63:0] k);
        logic ok;
        ok = 1'b1;
        for (int b = 0; b < 8; b++) ok = ok & (^k[8*b +: 8]);
        return ok;
    endfunction

endpackage

// ===== hw/rtl/des_block_cipher.sv =====
// DES block cipher top: input IP stage, 16 round stages, FP output stage.
// Depends on des_pkg, des_key_sched, des_feistel_stage.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-------------------------------------
//  in      | i_valid | o_stall | i_data_block
//  out     | o_valid | i_stall | o_result_block, o_key_parity_ok
//  cfg     | i_cfg_wr_en       | i_cfg_idx, i_cfg_data
//
// One word per cycle unless stalled; pipeline registers: IP register, 16 rounds, FP register.
// Subkeys are registered from the key and mode registers, which a config write updates first.
// Reset clears all valid bits; key resets to zero, mode to encrypt.
// A stall freezes the whole pipeline while the output holds a word.
module des_block_cipher import des_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BLK_W-1:0]     i_data_block,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BLK_W-1:0]     o_result_block,
    output logic                 o_key_parity_ok,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [KEY_W-1:0]     i_cfg_data
);
    t_subkeys    w_sub;
    logic        w_par;
    logic        w_adv;
    t_stage      w_st [ROUNDS+1];
    t_stage      r_in;
    logic        r_out_valid;
    logic [63:0] r_out_blk;
    logic        r_out_par;
    logic [63:0] w_ip;

    des_key_sched u_ks (
        .i_clk, .i_rst_n,
        .i_wr_en    (i_cfg_wr_en),
        .i_wr_idx   (i_cfg_idx),
        .i_wr_data  (i_cfg_data),
        .o_subkeys  (w_sub),
        .o_parity_ok(w_par)
    );

    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;
    assign w_ip    = perm_ip(i_data_block);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_adv) begin
            r_in.valid <= i_valid;
        end
        if (w_adv) begin
            r_in.parity_ok <= w_par;
            r_in.l         <= w_ip[63:32];
            r_in.r         <= w_ip[31:0];
        end
    end

    assign w_st[0] = r_in;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        des_feistel_stage u_rnd (
            .i_clk, .i_rst_n,
            .i_adv   (w_adv),
            .i_stage (w_st[g]),
            .i_subkey(w_sub[g]),
            .o_stage (w_st[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_st[ROUNDS].valid;
        end
        if (w_adv) begin
            r_out_blk <= perm_fp({w_st[ROUNDS].r, w_st[ROUNDS].l});
            r_out_par <= w_st[ROUNDS].parity_ok;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_block  = r_out_blk;
    assign o_key_parity_ok = r_out_par;
endmodule

// ===== hw/rtl/des_key_sched.sv =====
// DES key schedule: registers the 16 subkeys in round order for the mode.
// Depends on des_pkg.
module des_key_sched import des_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_wr_idx,
    input  logic [KEY_W-1:0]  i_wr_data,
    output t_subkeys          o_subkeys,
    output logic              o_parity_ok
);
    logic [KEY_W-1:0] r_key;
    logic             r_enc;
    t_subkeys         r_sub;
    t_subkeys         n_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_enc <= 1'b1;
        end else if (i_wr_en) begin
            unique case (i_wr_idx)
                REG_DES_KEY:      r_key <= i_wr_data;
                REG_ENCRYPT_MODE: r_enc <= i_wr_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [55:0] cd;
        logic [27:0] c, d;
        t_subkeys    fwd;
        cd = perm_pc1(r_key);
        c  = cd[55:28];
        d  = cd[27:0];
        for (int i = 0; i < ROUNDS; i++) begin
            if (ROT_TWO[i]) begin
                c = {c[25:0], c[27:26]};
                d = {d[25:0], d[27:26]};
            end else begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            fwd[i] = perm_pc2({c, d});
        end
        for (int i = 0; i < ROUNDS; i++)
            n_sub[i] = r_enc ? fwd[i] : fwd[ROUNDS-1-i];
    end

    always_ff @(posedge i_clk) begin
        r_sub <= n_sub;
    end

    assign o_subkeys   = r_sub;
    assign o_parity_ok = key_parity(r_key);
endmodule

// ===== hw/rtl/des_round.sv =====
// One Feistel round with its pipeline register and stall hold.
// Depends on des_pkg.
module des_feistel_stage import des_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_stage  i_stage,
    input  t_subkey i_subkey,
    output t_stage  o_stage
);
    t_stage r_stage;
    t_stage n_stage;

    always_comb begin
        n_stage.valid     = i_stage.valid;
        n_stage.parity_ok = i_stage.parity_ok;
        n_stage.l         = i_stage.r;
        n_stage.r         = i_stage.l ^ feistel(i_stage.r, i_subkey);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_adv) begin
            r_stage.parity_ok <= n_stage.parity_ok;
            r_stage.l         <= n_stage.l;
            r_stage.r         <= n_stage.r;
        end
    end

    assign o_stage = r_stage;
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for des_block_cipher: known-answer rows, then random blocks
// under changing keys and modes, checked against a DES predictor built on the des_pkg tables.
// Depends on des_pkg and des_block_cipher.
module testbench;
    import des_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int WDOG_LIMIT   = 4000;
    localparam int SEG_WORDS    = 48;
    localparam int PHASE_WORDS  = 580;

    typedef struct packed {
        logic [63:0] block;
        logic        parity;
    } t_cipher_out;

    typedef struct {
        logic [63:0] key;
        logic [63:0] mode_word;
        logic [63:0] data;
        bit          known;
        logic [63:0] known_block;
        logic        known_parity;
    } t_vector;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [BLK_W-1:0]     i_data_block;
    logic                 o_valid;
    logic                 i_stall;
    logic [BLK_W-1:0]     o_result_block;
    logic                 o_key_parity_ok;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [KEY_W-1:0]     i_cfg_data;

    // side info travelling with the word being offered
    logic                 word_known;
    t_cipher_out          word_known_out;

    logic [63:0]          key_copy;
    logic                 mode_copy;
    t_cipher_out          cipher_q[$];
    int                   err_cnt;
    int                   idle_cnt;
    int                   tx_idle_pct;
    int                   rx_idle_pct;
    bit                   hold_go;
    bit                   hold_done;

    des_block_cipher u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_block    (i_data_block),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_block  (o_result_block),
        .o_key_parity_ok (o_key_parity_ok),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] round_fn(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  g;
        int          row;
        int          col;
        for (int i = 0; i < 48; i++) x[47-i] = r[32-TAB_E[i]];
        x = x ^ k;
        for (int i = 0; i < 8; i++) begin
            g = x[47-6*i -: 6];
            row = int'({g[5], g[0]});
            col = int'(g[4:1]);
            s[31-4*i -: 4] = TAB_S[i][row*16 + col];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-TAB_P[i]];
        return p;
    endfunction

    function automatic logic odd_parity_bytes(input logic [63:0] k);
        int ones;
        for (int b = 0; b < 8; b++) begin
            ones = 0;
            for (int i = 0; i < 8; i++) ones += int'(k[8*b+i]);
            if (ones % 2 == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_cipher_out des_predict(input logic [63:0] key, input logic enc,
                                                input logic [63:0] blk);
        logic [47:0] sub[16];
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [63:0] v;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        int          sh;
        t_cipher_out res;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64-TAB_PC1[i]];
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 16; i++) begin
            sh = (i == 0 || i == 1 || i == 8 || i == 15) ? 1 : 2;
            c = (c << sh) | (c >> (28 - sh));
            d = (d << sh) | (d >> (28 - sh));
            cd = {c, d};
            for (int j = 0; j < 48; j++) sub[i][47-j] = cd[56-TAB_PC2[j]];
        end
        for (int i = 0; i < 64; i++) v[63-i] = blk[64-TAB_IP[i]];
        l = v[63:32];
        r = v[31:0];
        for (int i = 0; i < 16; i++) begin
            t = l ^ round_fn(r, enc ? sub[i] : sub[15-i]);
            l = r;
            r = t;
        end
        v = {r, l};
        for (int i = 0; i < 64; i++) res.block[63-i] = v[64-TAB_FP[i]];
        res.parity = odd_parity_bytes(key);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch %s got %h expected %h", $realtime, what, got, want);
        err_cnt++;
    endtask

    // scoreboard: push on input accept, compare on output accept
    always @(posedge i_clk) begin
        t_cipher_out want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                if (word_known) cipher_q.push_back(word_known_out);
                else cipher_q.push_back(des_predict(key_copy, mode_copy, i_data_block));
            end
            if (o_valid && !i_stall) begin
                if (cipher_q.size() == 0) begin
                    report_mismatch("unexpected word", o_result_block, 64'd0);
                end else begin
                    want = cipher_q.pop_front();
                    if (o_result_block !== want.block)
                        report_mismatch("result_block", o_result_block, want.block);
                    if (o_key_parity_ok !== want.parity)
                        report_mismatch("key_parity_ok", {63'd0, o_key_parity_ok},
                                        {63'd0, want.parity});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
                hold_done = 1'b1;
            end
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic send_word(input logic [63:0] d, input bit known, input t_cipher_out kv);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_block   <= d;
        word_known     <= known;
        word_known_out <= kv;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == REG_DES_KEY) key_copy = data;
        else if (idx == REG_ENCRYPT_MODE) mode_copy = data[0];
    endtask

    task automatic set_config(input logic [63:0] key, input logic [63:0] mode_word);
        if (key === key_copy && mode_word[0] === mode_copy) return;
        drain();
        write_reg(REG_DES_KEY, key);
        write_reg(REG_ENCRYPT_MODE, mode_word);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_key;
        logic [63:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(7))
            0: k = 64'd0;
            1: k = '1;
            2, 3: for (int b = 0; b < 8; b++) k[8*b] = ~^k[8*b+7 -: 7];
            default: ;
        endcase
        return k;
    endfunction

    t_vector vec[$];

    initial begin
        t_vector     v;
        t_cipher_out kv;
        logic [63:0] d;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data_block   = '0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        word_known     = 1'b0;
        word_known_out = '0;
        err_cnt        = 0;
        idle_cnt       = 0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        hold_go        = 1'b0;
        hold_done      = 1'b0;
        key_copy       = 64'd0;
        mode_copy      = 1'b1;

        // key, mode, data, known, block, parity
        vec.push_back('{64'd0, 64'd1, 64'd0, 1'b1, 64'h8CA64DE9C1B123A7, 1'b0});
        vec.push_back('{64'd0, 64'd1, '1, 1'b0, '0, 1'b0});
        vec.push_back('{64'h133457799BBCDFF1, 64'd1, 64'h0123456789ABCDEF, 1'b1,
                        64'h85E813540F0AB405, 1'b1});
        vec.push_back('{64'h133457799BBCDFF1, 64'd1, 64'h8000000000000000, 1'b0, '0, 1'b0});
        vec.push_back('{64'h133457799BBCDFF1, 64'd1, 64'h0000000000000001, 1'b0, '0, 1'b0});
        vec.push_back('{64'h133457799BBCDFF1, 64'd0, 64'h85E813540F0AB405, 1'b1,
                        64'h0123456789ABCDEF, 1'b1});
        vec.push_back('{64'h133457799BBCDFF1, 64'd0, 64'd0, 1'b0, '0, 1'b0});
        vec.push_back('{'1, 64'd1, '1, 1'b1, 64'h7359B2163E4EDC58, 1'b0});
        vec.push_back('{'1, 64'd1, 64'd0, 1'b0, '0, 1'b0});
        vec.push_back('{'1, '1, 64'h5555555555555555, 1'b0, '0, 1'b0});
        vec.push_back('{64'h0101010101010101, 64'hFFFFFFFFFFFFFFFE, 64'hAAAAAAAAAAAAAAAA,
                        1'b0, '0, 1'b0});
        vec.push_back('{64'h0101010101010101, 64'hFFFFFFFFFFFFFFFE, '1, 1'b0, '0, 1'b0});
        vec.push_back('{64'h0101010101010100, 64'h8000000000000001, 64'hFEDCBA9876543210,
                        1'b0, '0, 1'b0});
        vec.push_back('{64'h8000000000000000, 64'h2, 64'h0123456789ABCDEF, 1'b0, '0, 1'b0});
        vec.push_back('{64'h8000000000000000, 64'h3, 64'h0123456789ABCDEF, 1'b0, '0, 1'b0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 10;
        rx_idle_pct = 10;
        foreach (vec[n]) begin
            v = vec[n];
            set_config(v.key, v.mode_word);
            kv.block  = v.known_block;
            kv.parity = v.known_parity;
            send_word(v.data, v.known, kv);
        end

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 79 : 0;
            rx_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 23 : 0;
            for (int w = 0; w < PHASE_WORDS; w++) begin
                if (w % SEG_WORDS == 0)
                    set_config(rand_key(), {$urandom, $urandom});
                if (ph == 2 && w == 100) hold_go = 1'b1;
                d = {$urandom, $urandom};
                if ($urandom_range(15) == 0) d = $urandom_range(1) ? 64'd0 : '1;
                send_word(d, 1'b0, '0);
            end
        end

        drain();
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
